@@ hw/rtl/ewcc_pkg.sv @@
package ewcc_pkg;
  localparam int MirrorBytes = 4096;
  localparam int QueueDepth = 4096;
  localparam int PageBytes = 32;
  localparam int AddrW = 12;
  localparam int QIdxW = 12;
  localparam int CountW = 13;
  localparam int RunW = 6;

  localparam logic [2:0] KIND_LOAD = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_UPDATE = 3'd2;
  localparam logic [2:0] KIND_READ = 3'd3;
  localparam logic [2:0] KIND_DRAIN = 3'd4;
  localparam logic [2:0] KIND_DONE = 3'd5;

  localparam logic [1:0] RESP_READ = 2'd0;
  localparam logic [1:0] RESP_PAGE = 2'd1;
  localparam logic [1:0] RESP_DIRECT = 2'd2;
  localparam logic [1:0] RESP_STATUS = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [11:0] addr;
    logic [7:0] data;
    logic device_busy;
    logic write_ok;
  } req_t;

  typedef struct packed {
    logic [1:0] resp_kind;
    logic [11:0] out_addr;
    logic [7:0] out_data;
    logic last;
    logic [12:0] pending_count;
    logic [12:0] high_water;
    logic [31:0] overflow_count;
    logic burst_active;
  } resp_t;
endpackage

@@ hw/rtl/ewcc_if.sv @@
interface ewcc_req_if;
  import ewcc_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ewcc_resp_if;
  import ewcc_pkg::*;
  logic valid;
  logic ready;
  resp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ewcc_cfg_if;
  logic valid;
  logic ready;
  logic [12:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/eeprom_write_coalescing_cache.sv @@
// A non-drain item's result is registered into the output register; a drain presents its page
// bytes one at a time, each after the next queue entry has been read, with the final byte
// flagged as last. A new item is taken only once the last one's result has been taken, and
// a drain reads every queue entry on its own through the single read port of the queue
// memory. Reset clears the queue pointers, counters and threshold (512); the mirror and the
// queue memory are not cleared and need no clearing pass.
module eeprom_write_coalescing_cache (
  input logic clk,
  input logic rst,
  ewcc_req_if.sink    req,
  ewcc_resp_if.source resp,
  ewcc_cfg_if.sink    cfg
);
  import ewcc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOOK  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state;
  req_t cur;
  logic [QIdxW-1:0] head, tail;
  logic [CountW-1:0] count, high_mark;
  logic [31:0] overflow;
  logic [RunW-1:0] inflight;
  logic [12:0] threshold;

  // Drain bookkeeping: n counts bytes taken from the queue, limit caps the run.
  logic [RunW-1:0] run_n, run_limit;
  logic [AddrW-1:0] run_first;
  logic run_started;
  // The newest page byte is held back until the next entry shows whether it ends the run.
  resp_t held;

  // Output register.
  resp_t out_reg;
  logic out_valid;
  resp_t exec_resp;

  // Memories.
  logic m_we;
  logic [AddrW-1:0] m_waddr, m_raddr;
  logic [7:0] m_wdata, m_rdata;
  logic q_we;
  logic [QIdxW-1:0] q_raddr;
  logic [19:0] q_rdata;

  ewcc_ram #(.Width(8), .Depth(MirrorBytes)) u_mirror (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );
  ewcc_ram #(.Width(20), .Depth(QueueDepth)) u_queue (
    .clk, .we(q_we), .waddr(tail), .wdata({cur.addr, cur.data}),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  assign req.ready = (state == ST_IDLE) && !out_valid;
  assign cfg.ready = 1'b1;
  assign resp.valid = out_valid;
  assign resp.payload = out_reg;
  // The mirror is read in ST_LOOK for the captured item, so the byte is ready in ST_EXEC.
  assign m_raddr = cur.addr;
  assign m_waddr = cur.addr;
  assign m_wdata = cur.data;

  // Queue read address: the entry the drain will look at next.
  assign q_raddr = head + QIdxW'(run_n);

  wire full = count == CountW'(QueueDepth);
  wire [CountW-1:0] count_inc = count + CountW'(1);
  wire [31:0] overflow_inc = (overflow != '1) ? overflow + 32'd1 : overflow;
  wire [11:0] qe_addr = 12'(q_rdata[19:8]);
  wire [12:0] page_end = {1'b0, run_first & ~12'(PageBytes - 1)} + 13'(PageBytes);
  wire [12:0] want = {1'b0, run_first} + 13'(run_n);
  wire run_ok = (run_n < run_limit) &&
                (!run_started || ({1'b0, qe_addr} == want && want < page_end));
  wire do_write = (cur.kind == KIND_WRITE) ||
                  (cur.kind == KIND_UPDATE && m_rdata != cur.data);
  wire drain_go = (cur.kind == KIND_DRAIN) && !cur.device_busy && (count != '0);

  // Status after this item's update; values settle in ST_EXEC before use.
  function automatic resp_t mk(input logic [1:0] k, input logic [11:0] a,
                               input logic [7:0] d, input logic l,
                               input logic [CountW-1:0] c, input logic [CountW-1:0] h,
                               input logic [31:0] o, input logic [12:0] t);
    resp_t r;
    r.resp_kind = k; r.out_addr = a; r.out_data = d; r.last = l;
    r.pending_count = c; r.high_water = h; r.overflow_count = o;
    r.burst_active = c >= t;
    return r;
  endfunction

  // The single result of a non-drain item, or the status of a drain that emits nothing.
  always_comb begin
    exec_resp = mk(RESP_STATUS, '0, '0, 1'b1, count, high_mark, overflow, threshold);
    case (cur.kind)
      KIND_READ: exec_resp = mk(RESP_READ, cur.addr, m_rdata, 1'b1, count, high_mark,
                                overflow, threshold);
      KIND_WRITE, KIND_UPDATE: begin
        if (do_write && !full) begin
          exec_resp = mk(RESP_STATUS, '0, '0, 1'b1, count_inc,
                         (count_inc > high_mark) ? count_inc : high_mark,
                         overflow, threshold);
        end else if (do_write) begin
          exec_resp = mk(RESP_DIRECT, cur.addr, cur.data, 1'b1, count, high_mark,
                         overflow_inc, threshold);
        end
      end
      KIND_DONE: begin
        if (inflight != '0 && cur.write_ok) begin
          exec_resp = mk(RESP_STATUS, '0, '0, 1'b1, count - CountW'(inflight),
                         high_mark, overflow, threshold);
        end
      end
      default: ;
    endcase
  end

  assign m_we = (state == ST_EXEC) &&
                (cur.kind == KIND_LOAD || do_write);
  assign q_we = (state == ST_EXEC) && do_write && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head <= '0; tail <= '0; count <= '0; high_mark <= '0;
      overflow <= '0; inflight <= '0; threshold <= 13'd512;
      out_valid <= 1'b0; run_n <= '0; run_started <= 1'b0;
    end else begin
      if (cfg.valid) threshold <= cfg.data;
      if (state == ST_EXEC) out_valid <= !drain_go;
      else if (state == ST_DRAIN && run_started && (!out_valid || resp.ready))
        out_valid <= 1'b1;
      else if (resp.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          run_n <= '0;
          run_started <= 1'b0;
          if (req.valid && req.ready) begin
            cur <= req.payload;
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          // Mirror read data, or the next queue entry of a drain, is valid next cycle.
          state <= run_started ? ST_DRAIN : ST_EXEC;
        end
        ST_EXEC: begin
          state <= drain_go ? ST_DRAIN : ST_OUT;
          out_reg <= exec_resp;
          case (cur.kind)
            KIND_WRITE, KIND_UPDATE: begin
              if (do_write) begin
                if (!full) begin
                  tail <= tail + 1'b1;
                  count <= count_inc;
                  if (count_inc > high_mark) high_mark <= count_inc;
                end else begin
                  overflow <= overflow_inc;
                end
              end
            end
            KIND_DRAIN: begin
              if (drain_go) begin
                run_n <= '0;
                run_started <= 1'b0;
                run_limit <= (count > CountW'(PageBytes)) ? RunW'(PageBytes)
                                                          : RunW'(count);
              end
            end
            KIND_DONE: begin
              if (inflight != '0 && cur.write_ok) begin
                head <= head + QIdxW'(inflight);
                count <= count - CountW'(inflight);
              end
              inflight <= '0;
            end
            default: ;
          endcase
        end
        ST_DRAIN: begin
          // q_rdata holds entry head+run_n. The held byte leaves only once this entry
          // has shown whether the run goes on, so it can carry the right last flag.
          if (!run_started) begin
            run_first <= qe_addr;
            run_started <= 1'b1;
            held <= mk(RESP_PAGE, qe_addr, q_rdata[7:0], 1'b0, count, high_mark,
                       overflow, threshold);
            run_n <= run_n + 1'b1;
            state <= ST_LOOK;
          end else if (!out_valid || resp.ready) begin
            if (run_ok) begin
              out_reg <= held;
              held <= mk(RESP_PAGE, qe_addr, q_rdata[7:0], 1'b0, count, high_mark,
                         overflow, threshold);
              run_n <= run_n + 1'b1;
              state <= ST_LOOK;
            end else begin
              out_reg <= mk(held.resp_kind, held.out_addr, held.out_data, 1'b1, count,
                            high_mark, overflow, threshold);
              inflight <= run_n;
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/ewcc_ram.sv @@
module ewcc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
